### design/ckd_pkg.sv
`default_nettype none

package ckd_pkg;

  // Payload store geometry
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned LenW       = 7;

  // Register reset values
  localparam logic [7:0]      StartReset   = 8'hAA;
  localparam logic [LenW-1:0] LimitReset   = 7'd50;
  localparam logic [7:0]      DisplayReset = 8'h01;
  localparam logic [LenW-1:0] LimitCap     = LenW'(MaxPayload);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_START   = 2'd0,
    REG_LIMIT   = 2'd1,
    REG_DISPLAY = 2'd2,
    REG_NONE    = 2'd3
  } ckd_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_PLAY
  } ckd_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic ld_cmd;      // command byte taken
    logic ld_len;      // length byte taken
    logic ld_data;     // payload byte taken
    logic ld_status;   // status-only result into output register
    logic play_start;  // begin play-out, read entry 0
    logic ld_play;     // payload result into output register
  } ckd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_start;    // rx byte equals start value
    logic len_drop;    // rx byte exceeds effective limit
    logic len_zero;    // rx byte is zero
    logic data_done;   // this payload byte is the final one
    logic sum_ok;      // rx byte matches running sum
    logic empty;       // stored length is zero
    logic out_free;    // output register can take a result this cycle
    logic play_last;   // current play-out entry is the final one
  } ckd_sts_t;

endpackage

`default_nettype wire

### design/ckd_ram.sv
`default_nettype none

module ckd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/ckd_ctrl.sv
`default_nettype none

module ckd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ckd_pkg::ckd_sts_t sts_i,
  output ckd_pkg::ckd_cmd_t      cmd_o
);

  ckd_pkg::ckd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckd_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    logic acc;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    acc        = 1'b0;
    unique case (state_q)
      ckd_pkg::ST_HUNT: begin
        in_ready_o = 1'b1;
        acc        = in_valid_i;
        if (acc && sts_i.is_start) state_d = ckd_pkg::ST_CMD;
      end
      ckd_pkg::ST_CMD: begin
        in_ready_o   = 1'b1;
        acc          = in_valid_i;
        cmd_o.ld_cmd = acc;
        if (acc) state_d = ckd_pkg::ST_LEN;
      end
      ckd_pkg::ST_LEN: begin
        in_ready_o = 1'b1;
        acc        = in_valid_i;
        if (acc) begin
          if (sts_i.len_drop) begin
            state_d = ckd_pkg::ST_HUNT;
          end else begin
            cmd_o.ld_len = 1'b1;
            state_d = sts_i.len_zero ? ckd_pkg::ST_CHECK : ckd_pkg::ST_DATA;
          end
        end
      end
      ckd_pkg::ST_DATA: begin
        in_ready_o    = 1'b1;
        acc           = in_valid_i;
        cmd_o.ld_data = acc;
        if (acc && sts_i.data_done) state_d = ckd_pkg::ST_CHECK;
      end
      ckd_pkg::ST_CHECK: begin
        // verdict needs the output register
        in_ready_o = sts_i.out_free;
        acc        = in_valid_i && sts_i.out_free;
        if (acc) begin
          if (!sts_i.sum_ok || sts_i.empty) begin
            cmd_o.ld_status = 1'b1;
            state_d = ckd_pkg::ST_HUNT;
          end else begin
            cmd_o.play_start = 1'b1;
            state_d = ckd_pkg::ST_PLAY;
          end
        end
      end
      ckd_pkg::ST_PLAY: begin
        // read data for the current entry is waiting in the RAM register
        if (sts_i.out_free) begin
          cmd_o.ld_play = 1'b1;
          if (sts_i.play_last) state_d = ckd_pkg::ST_HUNT;
        end
      end
      default: begin
        state_d = ckd_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/ckd_dp.sv
`default_nettype none

module ckd_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  // input byte
  input  wire logic [7:0]        rx_byte_i,
  // output item
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   frame_status_o,
  output logic [7:0]             command_code_o,
  output logic                   is_display_o,
  output logic [ckd_pkg::LenW-1:0]  payload_length_o,
  output logic [7:0]             payload_value_o,
  output logic [ckd_pkg::AddrW-1:0] payload_index_o,
  output logic                   has_payload_o,
  output logic                   last_o,
  // controller link
  input  wire ckd_pkg::ckd_cmd_t cmd_i,
  output ckd_pkg::ckd_sts_t      sts_o
);

  localparam int unsigned LenW  = ckd_pkg::LenW;
  localparam int unsigned AddrW = ckd_pkg::AddrW;

  logic [7:0]      start_q, display_q;
  logic [LenW-1:0] limit_q, eff_limit;
  logic [7:0]      cmd_q, sum_q;
  logic [LenW-1:0] len_q, count_q;
  logic [AddrW-1:0] idx_q, idx_d, raddr;
  logic            re;
  logic [7:0]      rdata;
  logic            wr_en;
  logic [LenW:0]   count_inc;

  // output register
  logic            ov_q;
  logic            o_status_q, o_disp_q, o_has_q, o_last_q;
  logic [7:0]      o_cmd_q, o_val_q;
  logic [LenW-1:0] o_len_q;
  logic [AddrW-1:0] o_idx_q;

  // Configuration registers
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= ckd_pkg::StartReset;
      limit_q   <= ckd_pkg::LimitReset;
      display_q <= ckd_pkg::DisplayReset;
    end else if (wr_en) begin
      unique case (ckd_pkg::ckd_reg_e'(paddr[3:2]))
        ckd_pkg::REG_START:   start_q   <= pwdata[7:0];
        ckd_pkg::REG_LIMIT:   limit_q   <= pwdata[LenW-1:0];
        ckd_pkg::REG_DISPLAY: display_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    unique case (ckd_pkg::ckd_reg_e'(paddr[3:2]))
      ckd_pkg::REG_START:   prdata = {24'd0, start_q};
      ckd_pkg::REG_LIMIT:   prdata = {{(32-LenW){1'b0}}, limit_q};
      ckd_pkg::REG_DISPLAY: prdata = {24'd0, display_q};
      default:              prdata = '0;
    endcase
  end

  // Frame header, count and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cmd_i.ld_cmd) begin
        cmd_q <= rx_byte_i;
        sum_q <= rx_byte_i;
      end
      if (cmd_i.ld_len) begin
        len_q   <= rx_byte_i[LenW-1:0];
        count_q <= '0;
        sum_q   <= sum_q + rx_byte_i;
      end
      if (cmd_i.ld_data) begin
        count_q <= count_inc[LenW-1:0];
        sum_q   <= sum_q + rx_byte_i;
      end
    end
  end

  assign count_inc = {1'b0, count_q} + (LenW+1)'(1);
  assign eff_limit = (limit_q > ckd_pkg::LimitCap) ? ckd_pkg::LimitCap : limit_q;

  // Play-out index and read address
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.play_start) idx_d = '0;
    else if (cmd_i.ld_play && !sts_o.play_last) idx_d = idx_q + AddrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign re    = cmd_i.play_start || (cmd_i.ld_play && !sts_o.play_last);
  assign raddr = idx_d;

  // Payload store
  ckd_ram #(
    .Width (8),
    .Depth (ckd_pkg::MaxPayload)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_data),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Status to controller
  always_comb begin
    sts_o.is_start  = (rx_byte_i == start_q);
    sts_o.len_drop  = (rx_byte_i > {1'b0, eff_limit});
    sts_o.len_zero  = (rx_byte_i == 8'd0);
    sts_o.data_done = (count_inc >= {1'b0, len_q});
    sts_o.sum_ok    = (rx_byte_i == sum_q);
    sts_o.empty     = (len_q == '0);
    sts_o.out_free  = !ov_q || out_ready_i;
    sts_o.play_last = ({1'b0, idx_q} + LenW'(1)) == len_q;
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.ld_status || cmd_i.ld_play) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_status || cmd_i.ld_play) begin
      o_cmd_q    <= cmd_q;
      o_disp_q   <= (cmd_q == display_q);
      o_len_q    <= len_q;
      o_status_q <= cmd_i.ld_status && !sts_o.sum_ok;
      o_val_q    <= cmd_i.ld_play ? rdata : 8'd0;
      o_idx_q    <= cmd_i.ld_play ? idx_q : '0;
      o_has_q    <= cmd_i.ld_play;
      o_last_q   <= cmd_i.ld_status || sts_o.play_last;
    end
  end

  assign out_valid_o      = ov_q;
  assign frame_status_o   = o_status_q;
  assign command_code_o   = o_cmd_q;
  assign is_display_o     = o_disp_q;
  assign payload_length_o = o_len_q;
  assign payload_value_o  = o_val_q;
  assign payload_index_o  = o_idx_q;
  assign has_payload_o    = o_has_q;
  assign last_o           = o_last_q;

endmodule

`default_nettype wire

### design/checksummed_packet_deframer.sv
// Checksummed packet deframer. Takes one received byte per item and accepts one item per
// clock while hunting for the start value and reading command, length, payload and checksum
// bytes; of these only the checksum byte leads to a result. It is accepted only once the output
// register is free. A bad checksum or an empty frame gives a single status result. A good frame
// with payload stalls the input and plays the stored payload out of the two-port payload
// RAM at one result per cycle while the output is ready. The first result goes through the
// registered RAM read, then the output register. N payload bytes: N+4 bytes in, N results out.
// Frames longer than min(length_limit, 64) are dropped silently. Configuration registers sit at
// byte addresses 0 (start value), 4 (length limit) and 8 (display command).
`default_nettype none

module checksummed_packet_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             frame_status_o,
  output logic [7:0]       command_code_o,
  output logic             is_display_o,
  output logic [6:0]       payload_length_o,
  output logic [7:0]       payload_value_o,
  output logic [5:0]       payload_index_o,
  output logic             has_payload_o,
  output logic             last_o
);

  ckd_pkg::ckd_cmd_t cmd;
  ckd_pkg::ckd_sts_t sts;

  assign pready = 1'b1;

  // Sequencer
  ckd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Registers, payload store and output stage
  ckd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_status_o   (frame_status_o),
    .command_code_o   (command_code_o),
    .is_display_o     (is_display_o),
    .payload_length_o (payload_length_o),
    .payload_value_o  (payload_value_o),
    .payload_index_o  (payload_index_o),
    .has_payload_o    (has_payload_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

### design/ckd_checker.sv
`default_nettype none

module ckd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       frame_status_o,
  input wire logic [6:0] payload_length_o,
  input wire logic [7:0] payload_value_o,
  input wire logic [5:0] payload_index_o,
  input wire logic       has_payload_o,
  input wire logic       last_o
);

  // A waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // Status-only result is a single final item with cleared payload fields
  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_payload_o |->
      last_o && payload_value_o == 8'd0 && payload_index_o == 6'd0)
    else $error("status result malformed");

  // Payload items only from good frames, index inside the payload
  a_payload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_payload_o |->
      !frame_status_o && {1'b0, payload_index_o} < payload_length_o)
    else $error("payload item out of range");

  // Last flag sits on the final payload byte
  a_payload_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_payload_o |->
      last_o == (({1'b0, payload_index_o} + 7'd1) == payload_length_o))
    else $error("last flag misplaced");

endmodule

bind checksummed_packet_deframer ckd_checker u_ckd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_status_o   (frame_status_o),
  .payload_length_o (payload_length_o),
  .payload_value_o  (payload_value_o),
  .payload_index_o  (payload_index_o),
  .has_payload_o    (has_payload_o),
  .last_o           (last_o)
);

`default_nettype wire
